// ===== rtl/sspp_pkg.sv =====
// ---------------------------------------------------------------------------
// SMS-SUBMIT PDU parser package
// Result record, parse phase and element step encodings, field kind codes.
// ---------------------------------------------------------------------------
`default_nettype none

package sspp_pkg;

    // field kind codes carried with every result
    localparam logic [3:0] KIND_FIRST   = 4'd0;
    localparam logic [3:0] KIND_REF     = 4'd1;
    localparam logic [3:0] KIND_ALEN    = 4'd2;
    localparam logic [3:0] KIND_ATYPE   = 4'd3;
    localparam logic [3:0] KIND_DIGIT   = 4'd4;
    localparam logic [3:0] KIND_PID     = 4'd5;
    localparam logic [3:0] KIND_DCS     = 4'd6;
    localparam logic [3:0] KIND_VP      = 4'd7;
    localparam logic [3:0] KIND_UDL     = 4'd8;
    localparam logic [3:0] KIND_UDHL    = 4'd9;
    localparam logic [3:0] KIND_IE_TYPE = 4'd10;
    localparam logic [3:0] KIND_IE_LEN  = 4'd11;
    localparam logic [3:0] KIND_IE_DATA = 4'd12;
    localparam logic [3:0] KIND_UD      = 4'd13;

    localparam logic [7:0] ASCII_ZERO   = 8'd48;
    localparam logic [3:0] FILL_NIBBLE  = 4'hF;
    localparam logic [7:0] DIGITS_PER_OCTET = 8'd2;

    localparam int unsigned RES_DEPTH   = 4;
    localparam int unsigned RES_PTR_W   = $clog2(RES_DEPTH);
    localparam int unsigned RES_CNT_W   = RES_PTR_W + 1;

    typedef enum logic [11:0] {
        PH_FIRST  = 12'b0000_0000_0001,
        PH_REF    = 12'b0000_0000_0010,
        PH_ALEN   = 12'b0000_0000_0100,
        PH_ATYPE  = 12'b0000_0000_1000,
        PH_DIGITS = 12'b0000_0001_0000,
        PH_PID    = 12'b0000_0010_0000,
        PH_DCS    = 12'b0000_0100_0000,
        PH_VP     = 12'b0000_1000_0000,
        PH_UDL    = 12'b0001_0000_0000,
        PH_UDHL   = 12'b0010_0000_0000,
        PH_IE     = 12'b0100_0000_0000,
        PH_UD     = 12'b1000_0000_0000
    } phase_t;

    typedef enum logic [2:0] {
        STEP_TYPE = 3'b001,
        STEP_LEN  = 3'b010,
        STEP_DATA = 3'b100
    } step_t;

    typedef struct packed {
        logic [3:0] kind;
        logic [7:0] value;
        logic       reply_path;
        logic       udh_present;
        logic       status_report;
        logic       validity_present;
        logic       reject_duplicates;
        logic [1:0] message_type;
        logic       malformed;
        logic       last_of_run;
    } result_t;

    // what one accepted octet hands to the result queue
    typedef struct packed {
        logic    push;
        logic    two;
        result_t first;
        result_t second;
    } result_pair_t;

endpackage

`default_nettype wire

// ===== rtl/sspp_parse.sv =====
// ---------------------------------------------------------------------------
// SMS-SUBMIT PDU parser: field tagger
// Holds the parse state and tags the accepted octet with one or two results.
// ---------------------------------------------------------------------------
`default_nettype none

module sspp_parse (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  in_accept,
    input  wire logic [7:0]            data_byte,
    input  wire logic                  start_of_pdu,
    output sspp_pkg::result_pair_t     pair
);

    sspp_pkg::phase_t phase_reg, phase_next, phase_cur;
    sspp_pkg::step_t  step_reg, step_next;
    logic             header_flag_reg, header_flag_next;
    logic             validity_flag_reg, validity_flag_next;
    logic [7:0]       digits_reg, digits_next;
    logic [7:0]       hdr_left_reg, hdr_left_next;
    logic [7:0]       elem_left_reg, elem_left_next;

    logic [7:0]       hdr_dec;
    logic [7:0]       elem_dec;
    logic [7:0]       digits_dec;
    sspp_pkg::result_t r0, r1;
    logic             two;

    assign phase_cur  = start_of_pdu ? sspp_pkg::PH_FIRST : phase_reg;
    assign hdr_dec    = (hdr_left_reg != 8'd0) ? hdr_left_reg - 8'd1 : hdr_left_reg;
    assign elem_dec   = (elem_left_reg != 8'd0) ? elem_left_reg - 8'd1 : elem_left_reg;
    assign digits_dec = (digits_reg > sspp_pkg::DIGITS_PER_OCTET)
                        ? digits_reg - sspp_pkg::DIGITS_PER_OCTET : 8'd0;

    always_comb begin
        phase_next         = phase_cur;
        step_next          = step_reg;
        header_flag_next   = header_flag_reg;
        validity_flag_next = validity_flag_reg;
        digits_next        = digits_reg;
        hdr_left_next      = hdr_left_reg;
        elem_left_next     = elem_left_reg;
        two                = 1'b0;

        r0             = '0;
        r0.value       = data_byte;
        r0.last_of_run = 1'b1;
        r1             = '0;
        r1.kind        = sspp_pkg::KIND_DIGIT;
        r1.value       = {4'd0, data_byte[7:4]} + sspp_pkg::ASCII_ZERO;
        r1.last_of_run = 1'b1;

        unique case (phase_cur)
            sspp_pkg::PH_FIRST: begin
                r0.kind              = sspp_pkg::KIND_FIRST;
                r0.reply_path        = data_byte[7];
                r0.udh_present       = data_byte[6];
                r0.status_report     = data_byte[5];
                r0.validity_present  = data_byte[4] | data_byte[3];
                r0.reject_duplicates = data_byte[2];
                r0.message_type      = data_byte[1:0];
                header_flag_next     = data_byte[6];
                validity_flag_next   = data_byte[4] | data_byte[3];
                phase_next           = sspp_pkg::PH_REF;
            end
            sspp_pkg::PH_REF: begin
                r0.kind    = sspp_pkg::KIND_REF;
                phase_next = sspp_pkg::PH_ALEN;
            end
            sspp_pkg::PH_ALEN: begin
                r0.kind     = sspp_pkg::KIND_ALEN;
                digits_next = data_byte;
                phase_next  = sspp_pkg::PH_ATYPE;
            end
            sspp_pkg::PH_ATYPE: begin
                r0.kind    = sspp_pkg::KIND_ATYPE;
                phase_next = (digits_reg != 8'd0) ? sspp_pkg::PH_DIGITS : sspp_pkg::PH_PID;
            end
            sspp_pkg::PH_DIGITS: begin
                r0.kind  = sspp_pkg::KIND_DIGIT;
                r0.value = {4'd0, data_byte[3:0]} + sspp_pkg::ASCII_ZERO;
                // drop the high digit when it is the filler nibble
                two            = (data_byte[7:4] != sspp_pkg::FILL_NIBBLE);
                r0.last_of_run = !two;
                digits_next    = digits_dec;
                if (digits_dec == 8'd0) begin
                    phase_next = sspp_pkg::PH_PID;
                end
            end
            sspp_pkg::PH_PID: begin
                r0.kind    = sspp_pkg::KIND_PID;
                phase_next = sspp_pkg::PH_DCS;
            end
            sspp_pkg::PH_DCS: begin
                r0.kind    = sspp_pkg::KIND_DCS;
                phase_next = validity_flag_reg ? sspp_pkg::PH_VP : sspp_pkg::PH_UDL;
            end
            sspp_pkg::PH_VP: begin
                r0.kind    = sspp_pkg::KIND_VP;
                phase_next = sspp_pkg::PH_UDL;
            end
            sspp_pkg::PH_UDL: begin
                r0.kind    = sspp_pkg::KIND_UDL;
                phase_next = header_flag_reg ? sspp_pkg::PH_UDHL : sspp_pkg::PH_UD;
            end
            sspp_pkg::PH_UDHL: begin
                r0.kind        = sspp_pkg::KIND_UDHL;
                r0.malformed   = (data_byte == 8'd0);
                hdr_left_next  = data_byte;
                step_next      = sspp_pkg::STEP_TYPE;
                elem_left_next = 8'd0;
                phase_next     = (data_byte != 8'd0) ? sspp_pkg::PH_IE : sspp_pkg::PH_UD;
            end
            sspp_pkg::PH_IE: begin
                hdr_left_next = hdr_dec;
                unique case (step_reg)
                    sspp_pkg::STEP_TYPE: begin
                        r0.kind      = sspp_pkg::KIND_IE_TYPE;
                        r0.malformed = (hdr_dec == 8'd0);
                        step_next    = sspp_pkg::STEP_LEN;
                    end
                    sspp_pkg::STEP_LEN: begin
                        r0.kind        = sspp_pkg::KIND_IE_LEN;
                        r0.malformed   = (data_byte > hdr_dec);
                        elem_left_next = data_byte;
                        step_next      = (data_byte != 8'd0) ? sspp_pkg::STEP_DATA
                                                             : sspp_pkg::STEP_TYPE;
                    end
                    default: begin
                        r0.kind        = sspp_pkg::KIND_IE_DATA;
                        elem_left_next = elem_dec;
                        if (elem_dec == 8'd0) begin
                            step_next = sspp_pkg::STEP_TYPE;
                        end
                    end
                endcase
                // header exhausted: fall through to user data
                if (hdr_dec == 8'd0) begin
                    phase_next = sspp_pkg::PH_UD;
                    step_next  = sspp_pkg::STEP_TYPE;
                end
            end
            default: begin
                r0.kind    = sspp_pkg::KIND_UD;
                phase_next = sspp_pkg::PH_UD;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg         <= sspp_pkg::PH_FIRST;
            step_reg          <= sspp_pkg::STEP_TYPE;
            header_flag_reg   <= 1'b0;
            validity_flag_reg <= 1'b0;
            digits_reg        <= 8'd0;
            hdr_left_reg      <= 8'd0;
            elem_left_reg     <= 8'd0;
        end else if (in_accept) begin
            phase_reg         <= phase_next;
            step_reg          <= step_next;
            header_flag_reg   <= header_flag_next;
            validity_flag_reg <= validity_flag_next;
            digits_reg        <= digits_next;
            hdr_left_reg      <= hdr_left_next;
            elem_left_reg     <= elem_left_next;
        end
    end

    assign pair.push   = in_accept;
    assign pair.two    = two;
    assign pair.first  = r0;
    assign pair.second = r1;

endmodule

`default_nettype wire

// ===== rtl/sspp_resq.sv =====
// ---------------------------------------------------------------------------
// SMS-SUBMIT PDU parser: result queue
// Register queue taking one or two results per cycle, one out per ready cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module sspp_resq (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire sspp_pkg::result_pair_t pair,
    output logic                       room,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output sspp_pkg::result_t          out_res
);

    localparam int unsigned PTR_W = sspp_pkg::RES_PTR_W;
    localparam int unsigned CNT_W = sspp_pkg::RES_CNT_W;

    sspp_pkg::result_t entries [sspp_pkg::RES_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              pop;
    logic              push_two;
    logic [PTR_W-1:0]  wr_ptr_inc;

    assign pop        = out_valid && out_ready;
    assign push_two   = pair.push && pair.two;
    assign wr_ptr_inc = wr_ptr_reg + PTR_W'(1);

    // accept an octet only while two result slots are free
    assign room      = (count_reg <= CNT_W'(sspp_pkg::RES_DEPTH - 2));
    assign out_valid = (count_reg != '0);
    assign out_res   = entries[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg + PTR_W'(pair.push) + PTR_W'(push_two);
        rd_ptr_next = rd_ptr_reg + PTR_W'(pop);
        count_next  = count_reg + CNT_W'(pair.push) + CNT_W'(push_two) - CNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (pair.push) begin
            entries[wr_ptr_reg] <= pair.first;
        end
        if (push_two) begin
            entries[wr_ptr_inc] <= pair.second;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/sms_submit_pdu_parser_top.sv =====
// ---------------------------------------------------------------------------
// SMS-SUBMIT PDU parser, top level
// Tags each octet of a binary SMS-SUBMIT PDU with its field and decoded flags.
// ---------------------------------------------------------------------------
// Octets enter one per cycle on the s_ stream while s_tready is high; s_tuser
// marks the first octet of a PDU. Each octet yields one result on the m_ stream,
// except an address octet whose high nibble is not F, which yields two digit
// results (low digit first); m_tlast marks the final result of each octet.
// Results land in a four-entry queue in the same cycle the octet is accepted, so
// a result can appear in the cycle after its octet. An input octet is taken
// whenever the queue has two free slots: with m_tready held high the block sustains
// one octet per cycle for single-result octets; two-digit octets can fill the queue.
`default_nettype none

module sms_submit_pdu_parser_top (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
    input  wire logic        s_tuser,   // [0] start_of_pdu
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // [7:0] value, [8] reply_path, [9] udh_present,
                                        // [10] status_report, [11] validity_present,
                                        // [12] reject_duplicates, [14:13] message_type,
                                        // [15] malformed
    output logic [3:0]       m_tuser,   // [3:0] kind
    output logic             m_tlast    // last_of_run
);

    sspp_pkg::result_pair_t pair;
    sspp_pkg::result_t      res;
    logic                   room;
    logic                   in_accept;

    assign s_tready  = room;
    assign in_accept = s_tvalid && room;

    sspp_parse u_parse (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_accept    (in_accept),
        .data_byte    (s_tdata),
        .start_of_pdu (s_tuser),
        .pair         (pair)
    );

    sspp_resq u_resq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .pair      (pair),
        .room      (room),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (res)
    );

    assign m_tdata = {res.malformed, res.message_type, res.reject_duplicates,
                      res.validity_present, res.status_report, res.udh_present,
                      res.reply_path, res.value};
    assign m_tuser = res.kind;
    assign m_tlast = res.last_of_run;

endmodule

`default_nettype wire
